// ----- design/hifp_pkg.sv -----
package hifp_pkg;

  localparam int LAYOUT_LEN       = 29;
  localparam int DEFAULT_MAX_YEAR = 9999;
  localparam int EPOCH_YEAR       = 1970;
  // leaps_through(1969) = 492 - 19 + 4
  localparam int LEAPS_1969       = 477;
  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^14
  localparam int RECIP_100        = 5243;
  localparam int RECIP_SHIFT      = 19;
  localparam int DAYS_PER_YEAR    = 365;
  localparam int SEC_PER_DAY      = 86400;
  localparam int SEC_PER_HOUR     = 3600;
  localparam int SEC_PER_MIN      = 60;
  localparam int MAX_HOUR         = 23;
  localparam int MAX_MINUTE       = 59;
  localparam int MAX_SECOND       = 60;
  localparam int LAST_MONTH       = 11;

  localparam int SECS_W  = 38;
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int MONTH_W = 4;
  localparam int POS_W   = 5;
  localparam int DAYS_W  = 22;
  localparam int MUL_B_W = 17;
  localparam int QUOT_W  = 8;
  localparam int LEAP_W  = 13;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;

  typedef struct packed {
    logic                 fmt_ok;
    logic [FIELD_W-1:0]   day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [FIELD_W-1:0]   hour;
    logic [FIELD_W-1:0]   minute;
    logic [FIELD_W-1:0]   second;
  } hifp_fields_t;

  typedef struct packed {
    logic                 hit;
    logic [MONTH_W-1:0]   idx;
  } hifp_month_t;

  typedef enum logic [3:0] {
    CALC_IDLE,
    CALC_Q1,
    CALC_Q2,
    CALC_Q3,
    CALC_Q4,
    CALC_CHK,
    CALC_DAYS,
    CALC_SEC,
    CALC_HR,
    CALC_MIN,
    CALC_OUT
  } hifp_calc_state_t;

  function automatic logic day_name_ok(input logic [23:0] key);
    logic ok;
    case (key)
      "Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic hifp_month_t month_lookup(input logic [23:0] key);
    hifp_month_t r;
    r.hit = 1'b1;
    case (key)
      "Jan": r.idx = 4'd0;
      "Feb": r.idx = 4'd1;
      "Mar": r.idx = 4'd2;
      "Apr": r.idx = 4'd3;
      "May": r.idx = 4'd4;
      "Jun": r.idx = 4'd5;
      "Jul": r.idx = 4'd6;
      "Aug": r.idx = 4'd7;
      "Sep": r.idx = 4'd8;
      "Oct": r.idx = 4'd9;
      "Nov": r.idx = 4'd10;
      "Dec": r.idx = 4'd11;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1:                    d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- design/hifp_if.sv -----
interface hifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface hifp_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [37:0] unix_seconds;

  modport source (output valid, output date_valid, output unix_seconds, input ready);
  modport sink (input valid, input date_valid, input unix_seconds, output ready);
endinterface

// ----- design/hifp_lexer.sv -----
module hifp_lexer (
  input  logic                  clk,
  input  logic                  rst,
  hifp_in_if.sink               text_in,
  input  logic                  calc_idle,
  output logic                  start,
  output hifp_pkg::hifp_fields_t fields
);
  import hifp_pkg::*;

  logic [POS_W-1:0]   pos, pos_next;
  logic               err, err_next;
  logic [15:0]        name_chars, name_chars_next;
  logic [FIELD_W-1:0] day, day_next;
  logic [MONTH_W-1:0] month, month_next;
  logic [YEAR_W-1:0]  year, year_next;
  logic [FIELD_W-1:0] hour, hour_next;
  logic [FIELD_W-1:0] minute, minute_next;
  logic [FIELD_W-1:0] second, second_next;
  logic               accept;
  logic [7:0]         b;
  logic               is_digit;
  logic [3:0]         digit;
  hifp_month_t        mon_hit;

  function automatic logic [FIELD_W-1:0] acc7(input logic [FIELD_W-1:0] v,
                                              input logic [3:0] d);
    logic [FIELD_W-1:0] r;
    r = (v << 3) + (v << 1) + FIELD_W'(d);
    return r;
  endfunction

  function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] v,
                                              input logic [3:0] d);
    logic [YEAR_W-1:0] r;
    r = (v << 3) + (v << 1) + YEAR_W'(d);
    return r;
  endfunction

  assign text_in.ready = calc_idle;
  assign accept   = text_in.valid && text_in.ready;
  assign b        = text_in.text_byte;
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign digit    = 4'(b - 8'h30);
  assign mon_hit  = month_lookup({name_chars, b});

  assign start         = accept && (b == 8'h00);
  assign fields.fmt_ok = !err && (pos >= POS_W'(LAYOUT_LEN));
  assign fields.day    = day;
  assign fields.month  = month;
  assign fields.year   = year;
  assign fields.hour   = hour;
  assign fields.minute = minute;
  assign fields.second = second;

  always_comb begin
    pos_next        = pos;
    err_next        = err;
    name_chars_next = name_chars;
    day_next        = day;
    month_next      = month;
    year_next       = year;
    hour_next       = hour;
    minute_next     = minute;
    second_next     = second;
    if (accept) begin
      if (b == 8'h00) begin
        pos_next        = '0;
        err_next        = 1'b0;
        name_chars_next = '0;
        day_next        = '0;
        month_next      = '0;
        year_next       = '0;
        hour_next       = '0;
        minute_next     = '0;
        second_next     = '0;
      end else if (pos >= POS_W'(LAYOUT_LEN)) begin
        // trailing whitespace only
        if (b != 8'h20 && b != 8'h09) err_next = 1'b1;
      end else begin
        pos_next = pos + 1'b1;
        case (pos)
          5'd0, 5'd1, 5'd8, 5'd9: name_chars_next = {name_chars[7:0], b};
          5'd2: if (!day_name_ok({name_chars, b})) err_next = 1'b1;
          5'd10: begin
            if (mon_hit.hit) month_next = mon_hit.idx;
            else err_next = 1'b1;
          end
          5'd3: if (b != ",") err_next = 1'b1;
          5'd19, 5'd22: if (b != ":") err_next = 1'b1;
          5'd4, 5'd7, 5'd11, 5'd16, 5'd25: if (b != " ") err_next = 1'b1;
          5'd26: if (b != "G") err_next = 1'b1;
          5'd27: if (b != "M") err_next = 1'b1;
          5'd28: if (b != "T") err_next = 1'b1;
          5'd5, 5'd6: begin
            if (is_digit) day_next = acc7(day, digit);
            else err_next = 1'b1;
          end
          5'd12, 5'd13, 5'd14, 5'd15: begin
            if (is_digit) year_next = acc14(year, digit);
            else err_next = 1'b1;
          end
          5'd17, 5'd18: begin
            if (is_digit) hour_next = acc7(hour, digit);
            else err_next = 1'b1;
          end
          5'd20, 5'd21: begin
            if (is_digit) minute_next = acc7(minute, digit);
            else err_next = 1'b1;
          end
          default: begin
            if (is_digit) second_next = acc7(second, digit);
            else err_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      err        <= 1'b0;
      name_chars <= '0;
      day        <= '0;
      month      <= '0;
      year       <= '0;
      hour       <= '0;
      minute     <= '0;
      second     <= '0;
    end else begin
      pos        <= pos_next;
      err        <= err_next;
      name_chars <= name_chars_next;
      day        <= day_next;
      month      <= month_next;
      year       <= year_next;
      hour       <= hour_next;
      minute     <= minute_next;
      second     <= second_next;
    end
  end

endmodule

// ----- design/hifp_mac.sv -----
module hifp_mac (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hifp_pkg::DAYS_W-1:0]   a,
  input  logic [hifp_pkg::MUL_B_W-1:0]  b,
  input  logic [hifp_pkg::SECS_W-1:0]   addend,
  output logic [hifp_pkg::SECS_W-1:0]   res
);
  import hifp_pkg::*;

  logic [DAYS_W+MUL_B_W-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) res <= addend + prod[SECS_W-1:0];
  end

endmodule

// ----- design/hifp_calc.sv -----
module hifp_calc #(
  parameter int MAX_YEAR = hifp_pkg::DEFAULT_MAX_YEAR
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  hifp_pkg::hifp_fields_t fields,
  output logic                   idle,
  hifp_out_if.source             date_out
);
  import hifp_pkg::*;

  hifp_calc_state_t  state, state_next;
  hifp_fields_t      fld;
  logic [QUOT_W-1:0] q100a, q400a, q100b, q400b;
  logic [LEAP_W-1:0] la, lb;
  logic              leap;
  logic [4:0]        dim;
  logic              ok_now, ok;
  logic [DAYS_W-1:0] days_base_now, days_base;
  logic [YEAR_W-1:0] ym1;

  logic                mac_en;
  logic [DAYS_W-1:0]   mac_a;
  logic [MUL_B_W-1:0]  mac_b;
  logic [SECS_W-1:0]   mac_add;
  logic [SECS_W-1:0]   mac_res;
  logic                out_load;

  hifp_mac u_mac (
    .clk    (clk),
    .en     (mac_en),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .res    (mac_res)
  );

  assign idle  = (state == CALC_IDLE);
  assign ym1   = fld.year - 1'b1;
  assign q400b = mac_res[RECIP_SHIFT +: QUOT_W];

  // leaps_through(y) = y/4 - y/100 + y/400; y is leap when it differs from y-1
  assign la   = LEAP_W'(ym1[YEAR_W-1:2]) - LEAP_W'(q100a) + LEAP_W'(q400a);
  assign lb   = LEAP_W'(fld.year[YEAR_W-1:2]) - LEAP_W'(q100b) + LEAP_W'(q400b);
  assign leap = (la != lb);
  assign dim  = month_days(fld.month, leap);

  assign ok_now = fld.fmt_ok
               && (fld.month <= MONTH_W'(LAST_MONTH))
               && (fld.year >= YEAR_W'(EPOCH_YEAR))
               && (fld.year <= YEAR_W'(MAX_YEAR))
               && (fld.hour <= FIELD_W'(MAX_HOUR))
               && (fld.minute <= FIELD_W'(MAX_MINUTE))
               && (fld.second <= FIELD_W'(MAX_SECOND))
               && (fld.day != '0)
               && (fld.day <= FIELD_W'(dim));

  assign days_base_now = DAYS_W'(days_before(fld.month))
                       + DAYS_W'(leap && (fld.month > MONTH_FEB))
                       + DAYS_W'(fld.day) - 1'b1
                       + DAYS_W'(la) - DAYS_W'(LEAPS_1969);

  always_comb begin
    state_next = state;
    case (state)
      CALC_IDLE: if (start) state_next = CALC_Q1;
      CALC_Q1:   state_next = CALC_Q2;
      CALC_Q2:   state_next = CALC_Q3;
      CALC_Q3:   state_next = CALC_Q4;
      CALC_Q4:   state_next = CALC_CHK;
      CALC_CHK:  state_next = CALC_DAYS;
      CALC_DAYS: state_next = CALC_SEC;
      CALC_SEC:  state_next = CALC_HR;
      CALC_HR:   state_next = CALC_MIN;
      CALC_MIN:  state_next = CALC_OUT;
      CALC_OUT:  if (!date_out.valid || date_out.ready) state_next = CALC_IDLE;
      default:   state_next = CALC_IDLE;
    endcase
  end

  always_comb begin
    mac_en   = 1'b0;
    mac_a    = '0;
    mac_b    = '0;
    mac_add  = '0;
    out_load = 1'b0;
    case (state)
      CALC_Q1: begin
        mac_en = 1'b1;
        mac_a  = DAYS_W'(ym1);
        mac_b  = MUL_B_W'(RECIP_100);
      end
      CALC_Q2: begin
        mac_en = 1'b1;
        mac_a  = DAYS_W'(ym1[YEAR_W-1:2]);
        mac_b  = MUL_B_W'(RECIP_100);
      end
      CALC_Q3: begin
        mac_en = 1'b1;
        mac_a  = DAYS_W'(fld.year);
        mac_b  = MUL_B_W'(RECIP_100);
      end
      CALC_Q4: begin
        mac_en = 1'b1;
        mac_a  = DAYS_W'(fld.year[YEAR_W-1:2]);
        mac_b  = MUL_B_W'(RECIP_100);
      end
      CALC_DAYS: begin
        mac_en  = 1'b1;
        mac_a   = DAYS_W'(fld.year - YEAR_W'(EPOCH_YEAR));
        mac_b   = MUL_B_W'(DAYS_PER_YEAR);
        mac_add = SECS_W'(days_base);
      end
      CALC_SEC: begin
        mac_en  = 1'b1;
        mac_a   = mac_res[DAYS_W-1:0];
        mac_b   = MUL_B_W'(SEC_PER_DAY);
        mac_add = SECS_W'(fld.second);
      end
      CALC_HR: begin
        mac_en  = 1'b1;
        mac_a   = DAYS_W'(fld.hour);
        mac_b   = MUL_B_W'(SEC_PER_HOUR);
        mac_add = mac_res;
      end
      CALC_MIN: begin
        mac_en  = 1'b1;
        mac_a   = DAYS_W'(fld.minute);
        mac_b   = MUL_B_W'(SEC_PER_MIN);
        mac_add = mac_res;
      end
      CALC_OUT: out_load = !date_out.valid || date_out.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && idle) fld <= fields;
    if (state == CALC_Q2) q100a <= mac_res[RECIP_SHIFT +: QUOT_W];
    if (state == CALC_Q3) q400a <= mac_res[RECIP_SHIFT +: QUOT_W];
    if (state == CALC_Q4) q100b <= mac_res[RECIP_SHIFT +: QUOT_W];
    if (state == CALC_CHK) begin
      ok        <= ok_now;
      days_base <= days_base_now;
    end
    if (out_load) begin
      date_out.date_valid   <= ok;
      date_out.unix_seconds <= ok ? mac_res : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= CALC_IDLE;
      date_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) date_out.valid <= 1'b1;
      else if (date_out.ready) date_out.valid <= 1'b0;
    end
  end

endmodule

// ----- design/http_imf_fixdate_parser.sv -----
// IMF-fixdate parser: takes "Wdy, DD Mon YYYY HH:MM:SS GMT" one byte a beat, optional
// trailing spaces or tabs, ended by a zero byte, and returns one beat per string with a
// valid flag and the Unix seconds (zero when invalid). Every nonzero byte is accepted as
// soon as it is offered. After the zero byte the input is held off while a small sequencer
// runs the year-to-seconds conversion through one shared multiply-add unit (four
// reciprocal multiplies for the leap-year counts, then the day and time products); the
// result then sits in an output register, and input resumes once it is loaded there.
module http_imf_fixdate_parser #(
  parameter int MAX_YEAR = hifp_pkg::DEFAULT_MAX_YEAR
) (
  input  logic        clk,
  input  logic        rst,
  hifp_in_if.sink     text_in,
  hifp_out_if.source  date_out
);
  import hifp_pkg::*;

  logic         calc_idle;
  logic         start;
  hifp_fields_t fields;

  hifp_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .calc_idle (calc_idle),
    .start     (start),
    .fields    (fields)
  );

  hifp_calc #(
    .MAX_YEAR (MAX_YEAR)
  ) u_calc (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .fields   (fields),
    .idle     (calc_idle),
    .date_out (date_out)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    date_out.valid && !date_out.date_valid |-> date_out.unix_seconds == '0)
    else $error("invalid date with nonzero seconds");

  // a leap second on the last day of the last year lands exactly on the bound
  a_valid_bound: assert property (@(posedge clk) disable iff (rst)
    date_out.valid && date_out.date_valid |-> date_out.unix_seconds <= 38'd253402300800)
    else $error("seconds out of range");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    text_in.valid && text_in.ready && text_in.text_byte == 8'h00 |=> !text_in.ready)
    else $error("input taken during conversion");

endmodule
